// ----- sv/efd_pkg.sv -----
package efd_pkg;

  localparam logic [9:0] PHY_DEPTH = 10'd512;

  localparam logic [9:0]  RST_USABLE_LENGTH = 10'd504;
  localparam logic [10:0] RST_LOG_SIZE      = 11'd512;
  localparam logic [3:0]  RST_START_BANK    = 4'd0;
  localparam logic [4:0]  RST_BANK_COUNT    = 5'd1;

  localparam logic [1:0] REG_USABLE_LENGTH = 2'd0;
  localparam logic [1:0] REG_LOG_SIZE      = 2'd1;
  localparam logic [1:0] REG_START_BANK    = 2'd2;
  localparam logic [1:0] REG_BANK_COUNT    = 2'd3;

  localparam logic [1:0] PH_HDR1 = 2'd0;
  localparam logic [1:0] PH_HDR2 = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  localparam logic [2:0] OP_NONE      = 3'd0;
  localparam logic [2:0] OP_FIN_FALSE = 3'd1;
  localparam logic [2:0] OP_HOLD      = 3'd2;
  localparam logic [2:0] OP_REPLAY    = 3'd3;
  localparam logic [2:0] OP_PARSE_IN  = 3'd4;
  localparam logic [2:0] OP_PARSE_FF  = 3'd5;
  localparam logic [2:0] OP_FIN_FLUSH = 3'd6;
  localparam logic [2:0] OP_REPORT    = 3'd7;

  typedef struct packed {
    logic       capture;
    logic [2:0] op;
  } cmd_t;

  typedef struct packed {
    logic       over_limit;
    logic       bank_done;
    logic [1:0] phase;
    logic       pos_ge_u;
    logic       byte_ff;
    logic       held_zero;
    logic       held_one;
    logic       cur_last;
    logic       will_emit;
    logic       out_free;
  } status_t;

endpackage

// ----- sv/efd_ctrl.sv -----
module efd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  efd_pkg::status_t status,
  output efd_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PUSH   = 3'd1;
  localparam logic [2:0] S_REPLAY = 3'd2;
  localparam logic [2:0] S_PARSE  = 3'd3;
  localparam logic [2:0] S_FLUSH  = 3'd4;
  localparam logic [2:0] S_REPORT = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] after_item;

  assign item_stall  = (state != S_IDLE);
  assign cmd.capture = item_valid && (state == S_IDLE);
  assign after_item  = status.cur_last ? S_FLUSH : S_IDLE;

  always_comb begin
    state_next = state;
    cmd.op     = efd_pkg::OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (item_valid && !status.over_limit) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        if (status.bank_done) begin
          state_next = after_item;
        end else if (status.phase == efd_pkg::PH_HDR1 && status.pos_ge_u) begin
          cmd.op     = efd_pkg::OP_FIN_FALSE;
          state_next = after_item;
        end else if (status.phase == efd_pkg::PH_HDR1 && status.byte_ff) begin
          cmd.op     = efd_pkg::OP_HOLD;
          state_next = after_item;
        end else if (status.phase == efd_pkg::PH_HDR1 && !status.held_zero) begin
          state_next = S_REPLAY;
        end else begin
          state_next = S_PARSE;
        end
      end
      S_REPLAY: begin
        cmd.op = efd_pkg::OP_REPLAY;
        if (status.held_one) begin
          state_next = S_PARSE;
        end
      end
      S_PARSE: begin
        if (!status.will_emit || status.out_free) begin
          cmd.op     = efd_pkg::OP_PARSE_IN;
          state_next = after_item;
        end
      end
      S_FLUSH: begin
        if (status.bank_done) begin
          state_next = S_REPORT;
        end else if (status.phase == efd_pkg::PH_HDR1) begin
          cmd.op     = efd_pkg::OP_FIN_FLUSH;
          state_next = S_REPORT;
        end else if (!status.will_emit || status.out_free) begin
          cmd.op = efd_pkg::OP_PARSE_FF;
        end
      end
      S_REPORT: begin
        if (status.out_free) begin
          cmd.op     = efd_pkg::OP_REPORT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- sv/efd_dp.sv -----
module efd_dp (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [10:0]      cfg_data,
  input  logic [7:0]       phys_byte,
  input  logic             bank_last,
  input  efd_pkg::cmd_t    cmd,
  output efd_pkg::status_t status,
  output logic             result_valid,
  input  logic             result_stall,
  output logic             kind,
  output logic [9:0]       log_address,
  output logic [7:0]       log_value,
  output logic             addr_error,
  output logic [3:0]       bank_index,
  output logic [9:0]       used_length,
  output logic             end_found,
  output logic [3:0]       current_bank,
  output logic             last
);

  // first k >= from whose word bit in mask is clear; 8 when none
  function automatic logic [3:0] next_sel(input logic [3:0] mask, input logic [3:0] from);
    logic [3:0] sel;
    logic       hit;
    sel = 4'd8;
    hit = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (!hit && (4'(k) >= from) && !mask[k >> 1]) begin
        sel = 4'(k);
        hit = 1'b1;
      end
    end
    return sel;
  endfunction

  logic [9:0]  usable_length;
  logic [10:0] log_size;
  logic [3:0]  start_bank;
  logic [4:0]  bank_count;

  logic [2:0]  held, held_next;
  logic [9:0]  position, position_next;
  logic [1:0]  phase, phase_next;
  logic [2:0]  fh_hi, fh_hi_next;
  logic [9:0]  base_address, base_address_next;
  logic [3:0]  word_mask, word_mask_next;
  logic [2:0]  word_index, word_index_next;
  logic [4:0]  bank_counter, bank_counter_next;
  logic        bank_done, bank_done_next;
  logic [3:0]  nonempty_bank, nonempty_bank_next;
  logic        end_flag, end_flag_next;
  logic [7:0]  cur_byte;
  logic        cur_last;

  logic [9:0]  usable_eff;
  logic        pos_ge_u;
  logic [7:0]  pbyte;
  logic [3:0]  sel;
  logic        emit;
  logic        emit_last;
  logic [9:0]  emit_addr;
  logic        load_write;
  logic        load_report;
  logic        out_free;
  logic        parse_op;

  assign usable_eff = (usable_length > efd_pkg::PHY_DEPTH) ? efd_pkg::PHY_DEPTH : usable_length;
  assign pos_ge_u   = (position >= usable_eff);
  assign pbyte      = (cmd.op == efd_pkg::OP_PARSE_IN) ? cur_byte : 8'hff;
  assign emit_addr  = base_address + {7'd0, word_index};
  assign out_free   = !result_valid || !result_stall;
  assign parse_op   = (cmd.op == efd_pkg::OP_REPLAY) || (cmd.op == efd_pkg::OP_PARSE_IN) ||
                      (cmd.op == efd_pkg::OP_PARSE_FF);

  assign status.over_limit = ({1'b0, bank_counter} >= ({2'd0, start_bank} + {1'b0, bank_count}));
  assign status.bank_done  = bank_done;
  assign status.phase      = phase;
  assign status.pos_ge_u   = pos_ge_u;
  assign status.byte_ff    = (cur_byte == 8'hff);
  assign status.held_zero  = (held == 3'd0);
  assign status.held_one   = (held == 3'd1);
  assign status.cur_last   = cur_last;
  assign status.will_emit  = (phase == efd_pkg::PH_DATA) && !bank_done;
  assign status.out_free   = out_free;

  always_comb begin
    held_next          = held;
    position_next      = position;
    phase_next         = phase;
    fh_hi_next         = fh_hi;
    base_address_next  = base_address;
    word_mask_next     = word_mask;
    word_index_next    = word_index;
    bank_counter_next  = bank_counter;
    bank_done_next     = bank_done;
    nonempty_bank_next = nonempty_bank;
    end_flag_next      = end_flag;
    sel                = 4'd8;
    emit               = 1'b0;
    emit_last          = 1'b0;
    load_report        = 1'b0;

    case (cmd.op)
      efd_pkg::OP_FIN_FALSE: begin
        bank_done_next = 1'b1;
        end_flag_next  = 1'b0;
      end
      efd_pkg::OP_HOLD: begin
        if (held == 3'd7) begin
          held_next      = 3'd0;
          bank_done_next = 1'b1;
          end_flag_next  = 1'b1;
          if (position != 10'd0) begin
            nonempty_bank_next = bank_counter[3:0];
          end
        end else begin
          held_next = held + 3'd1;
        end
      end
      efd_pkg::OP_FIN_FLUSH: begin
        held_next      = 3'd0;
        bank_done_next = 1'b1;
        end_flag_next  = !pos_ge_u;
        if (!pos_ge_u && position != 10'd0) begin
          nonempty_bank_next = bank_counter[3:0];
        end
      end
      efd_pkg::OP_REPORT: begin
        load_report        = 1'b1;
        bank_counter_next  = bank_counter + 5'd1;
        held_next          = 3'd0;
        position_next      = 10'd0;
        phase_next         = efd_pkg::PH_HDR1;
        fh_hi_next         = 3'd0;
        base_address_next  = 10'd0;
        word_mask_next     = 4'hf;
        word_index_next    = 3'd0;
        bank_done_next     = 1'b0;
        end_flag_next      = 1'b0;
      end
      default: ;
    endcase

    if (parse_op) begin
      if (cmd.op == efd_pkg::OP_REPLAY) begin
        held_next = held - 3'd1;
      end
      if (!bank_done) begin
        case (phase)
          efd_pkg::PH_HDR1: begin
            if (pos_ge_u) begin
              bank_done_next = 1'b1;
              end_flag_next  = 1'b0;
            end else begin
              position_next = position + 10'd1;
              if (pbyte[3:0] != 4'hf) begin
                base_address_next = {3'd0, pbyte[7:4], 3'd0};
                word_mask_next    = pbyte[3:0];
                sel               = next_sel(pbyte[3:0], 4'd0);
                phase_next        = sel[3] ? efd_pkg::PH_HDR1 : efd_pkg::PH_DATA;
                word_index_next   = sel[2:0];
              end else begin
                fh_hi_next = pbyte[7:5];
                phase_next = efd_pkg::PH_HDR2;
              end
            end
          end
          efd_pkg::PH_HDR2: begin
            position_next     = position + 10'd1;
            base_address_next = {pbyte[7:4], fh_hi, 3'd0};
            word_mask_next    = pbyte[3:0];
            sel               = next_sel(pbyte[3:0], 4'd0);
            phase_next        = sel[3] ? efd_pkg::PH_HDR1 : efd_pkg::PH_DATA;
            word_index_next   = sel[2:0];
          end
          default: begin
            position_next   = position + 10'd1;
            emit            = 1'b1;
            emit_last       = (cmd.op == efd_pkg::OP_PARSE_IN) && !cur_last;
            sel             = next_sel(word_mask, {1'b0, word_index} + 4'd1);
            word_index_next = sel[2:0];
            if (sel[3]) begin
              phase_next = efd_pkg::PH_HDR1;
            end
          end
        endcase
      end
    end

    if (cfg_write && cfg_index == efd_pkg::REG_START_BANK) begin
      bank_counter_next  = {1'b0, cfg_data[3:0]};
      nonempty_bank_next = cfg_data[3:0];
      held_next          = 3'd0;
      position_next      = 10'd0;
      phase_next         = efd_pkg::PH_HDR1;
      fh_hi_next         = 3'd0;
      base_address_next  = 10'd0;
      word_mask_next     = 4'hf;
      word_index_next    = 3'd0;
      bank_done_next     = 1'b0;
      end_flag_next      = 1'b0;
    end
  end

  assign load_write = emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      usable_length <= efd_pkg::RST_USABLE_LENGTH;
      log_size      <= efd_pkg::RST_LOG_SIZE;
      start_bank    <= efd_pkg::RST_START_BANK;
      bank_count    <= efd_pkg::RST_BANK_COUNT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        efd_pkg::REG_USABLE_LENGTH: usable_length <= cfg_data[9:0];
        efd_pkg::REG_LOG_SIZE:      log_size      <= cfg_data;
        efd_pkg::REG_START_BANK:    start_bank    <= cfg_data[3:0];
        efd_pkg::REG_BANK_COUNT:    bank_count    <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held          <= 3'd0;
      position      <= 10'd0;
      phase         <= efd_pkg::PH_HDR1;
      fh_hi         <= 3'd0;
      base_address  <= 10'd0;
      word_mask     <= 4'hf;
      word_index    <= 3'd0;
      bank_counter  <= {1'b0, efd_pkg::RST_START_BANK};
      bank_done     <= 1'b0;
      nonempty_bank <= efd_pkg::RST_START_BANK;
      end_flag      <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      held          <= held_next;
      position      <= position_next;
      phase         <= phase_next;
      fh_hi         <= fh_hi_next;
      base_address  <= base_address_next;
      word_mask     <= word_mask_next;
      word_index    <= word_index_next;
      bank_counter  <= bank_counter_next;
      bank_done     <= bank_done_next;
      nonempty_bank <= nonempty_bank_next;
      end_flag      <= end_flag_next;
      if (load_write || load_report) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_byte <= phys_byte;
      cur_last <= bank_last;
    end
    if (load_write) begin
      kind         <= 1'b0;
      log_address  <= emit_addr;
      log_value    <= pbyte;
      addr_error   <= ({1'b0, emit_addr} >= log_size);
      bank_index   <= bank_counter[3:0];
      used_length  <= 10'd0;
      end_found    <= 1'b0;
      current_bank <= nonempty_bank;
      last         <= emit_last;
    end else if (load_report) begin
      kind         <= 1'b1;
      log_address  <= 10'd0;
      log_value    <= 8'd0;
      addr_error   <= 1'b0;
      bank_index   <= bank_counter[3:0];
      used_length  <= position;
      end_found    <= end_flag;
      current_bank <= nonempty_bank;
      last         <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !((load_write || load_report) && result_valid && result_stall))
    else $error("result register overwritten while stalled");

  a_report_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == efd_pkg::OP_REPORT && !cfg_write) |=> (position == 10'd0 && !bank_done))
    else $error("bank state not cleared after report");

  a_data_word_selected: assert property (@(posedge clk) disable iff (rst)
    (phase == efd_pkg::PH_DATA) |-> !word_mask[word_index[2:1]])
    else $error("data phase on unselected word");

  a_held_not_data: assert property (@(posedge clk) disable iff (rst)
    (held != 3'd0) |-> (phase != efd_pkg::PH_DATA))
    else $error("held window bytes in data phase");
`endif

endmodule

// ----- sv/efuse_map_decoder.sv -----
// Flow: an item is captured, passes the push state, replays any held window
//   bytes (up to 7), then is parsed; a data byte's write is then registered.
// Items: a new item is taken only once the last is done; bank_last adds a
//   flush of remaining data bytes plus an end of bank report.
// Reset: registers to 504/512/0/1, bank parse restarts at bank 0, result
//   register empty.
module efuse_map_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [7:0]  phys_byte,
  input  logic        bank_last,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        kind,
  output logic [9:0]  log_address,
  output logic [7:0]  log_value,
  output logic        addr_error,
  output logic [3:0]  bank_index,
  output logic [9:0]  used_length,
  output logic        end_found,
  output logic [3:0]  current_bank,
  output logic        last
);

  efd_pkg::cmd_t    cmd;
  efd_pkg::status_t status;

  efd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  efd_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .phys_byte    (phys_byte),
    .bank_last    (bank_last),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .log_address  (log_address),
    .log_value    (log_value),
    .addr_error   (addr_error),
    .bank_index   (bank_index),
    .used_length  (used_length),
    .end_found    (end_found),
    .current_bank (current_bank),
    .last         (last)
  );

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int LOG_DEPTH = 1024;
  localparam int MAX_PER_ITEM = 9;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 24;

  typedef struct packed {
    logic       kind;
    logic [9:0] addr;
    logic [7:0] value;
    logic       err;
    logic [3:0] bank;
    logic [9:0] used;
    logic       found;
    logic [3:0] cur_bank;
    logic       last;
  } fuse_result_t;

  class log_write_board;
    int unsigned usable_len, log_sz, first_bank, num_banks;
    int unsigned held, pos, hdr1, base, widx, bank_ctr, nonempty, used;
    logic [1:0] phase;
    logic [3:0] mask;
    bit done, found;
    fuse_result_t pending_writes[$];
    fuse_result_t batch[$];
    int mismatches;
    int checked;

    function new();
      usable_len = efd_pkg::RST_USABLE_LENGTH;
      log_sz = efd_pkg::RST_LOG_SIZE;
      first_bank = efd_pkg::RST_START_BANK;
      num_banks = efd_pkg::RST_BANK_COUNT;
      bank_ctr = first_bank;
      nonempty = first_bank;
      mismatches = 0;
      checked = 0;
      clear_bank();
    endfunction

    function void clear_bank();
      held = 0;
      pos = 0;
      phase = efd_pkg::PH_HDR1;
      hdr1 = 0;
      base = 0;
      mask = 4'hf;
      widx = 0;
      done = 0;
      found = 0;
      used = 0;
    endfunction

    function int unsigned usable_eff();
      return (usable_len < efd_pkg::PHY_DEPTH) ? usable_len : efd_pkg::PHY_DEPTH;
    endfunction

    function void emit(logic k, int unsigned a, logic [7:0] v, logic e, int unsigned u,
                       logic f);
      fuse_result_t r;
      if (batch.size() >= MAX_PER_ITEM) return;
      r.kind = k;
      r.addr = a[9:0];
      r.value = v;
      r.err = e;
      r.bank = bank_ctr[3:0];
      r.used = u[9:0];
      r.found = f;
      r.cur_bank = nonempty[3:0];
      r.last = 1'b0;
      batch.push_back(r);
    endfunction

    function void finish_bank(bit f);
      done = 1;
      found = f;
      used = (pos > 1023) ? 1023 : pos;
      if (f && pos != 0) nonempty = bank_ctr & 4'hf;
    endfunction

    function int unsigned next_word(logic [3:0] m, int unsigned from);
      for (int unsigned k = from; k < 8; k++) begin
        if (!m[k >> 1]) return k;
      end
      return 8;
    endfunction

    function void start_data();
      widx = next_word(mask, 0);
      phase = (widx < 8) ? efd_pkg::PH_DATA : efd_pkg::PH_HDR1;
    endfunction

    function void decode_byte(logic [7:0] v);
      int unsigned a;
      if (done) return;
      if (phase == efd_pkg::PH_HDR1) begin
        if (pos >= usable_eff()) begin
          finish_bank(0);
          return;
        end
        pos++;
        if (v[3:0] != 4'hf) begin
          base = v[7:4] * 8;
          mask = v[3:0];
          start_data();
        end else begin
          hdr1 = v;
          phase = efd_pkg::PH_HDR2;
        end
      end else if (phase == efd_pkg::PH_HDR2) begin
        pos++;
        base = (hdr1 >> 5) * 8 + v[7:4] * 64;
        mask = v[3:0];
        start_data();
      end else begin
        pos++;
        a = base + widx;
        emit(1'b0, a, v, (a >= log_sz || a >= LOG_DEPTH), 0, 1'b0);
        widx = next_word(mask, widx + 1);
        if (widx >= 8) phase = efd_pkg::PH_HDR1;
      end
    endfunction

    function void note_byte(logic [7:0] v, logic bl);
      batch.delete();
      if (bank_ctr >= first_bank + num_banks) return;
      if (!done) begin
        if (phase == efd_pkg::PH_HDR1 && pos >= usable_eff()) begin
          finish_bank(0);
        end else if (phase == efd_pkg::PH_HDR1 && v == 8'hff) begin
          held++;
          if (held >= 8) begin
            held = 0;
            finish_bank(1);
          end
        end else begin
          if (phase == efd_pkg::PH_HDR1) begin
            for (int unsigned k = 0; k < held; k++) decode_byte(8'hff);
            held = 0;
          end
          decode_byte(v);
        end
      end
      if (bl) begin
        for (int k = 0; k < 16 && !done; k++) begin
          if (phase == efd_pkg::PH_HDR1) begin
            held = 0;
            finish_bank(pos < usable_eff());
          end else begin
            decode_byte(8'hff);
          end
        end
        emit(1'b1, 0, 8'h00, 1'b0, used, found);
        bank_ctr++;
        clear_bank();
      end
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) pending_writes.push_back(batch[i]);
    endfunction

    function void set_reg(logic [1:0] idx, logic [10:0] val);
      case (idx)
        efd_pkg::REG_USABLE_LENGTH: usable_len = val[9:0];
        efd_pkg::REG_LOG_SIZE: log_sz = val;
        efd_pkg::REG_START_BANK: begin
          first_bank = val[3:0];
          bank_ctr = first_bank;
          nonempty = first_bank;
          clear_bank();
        end
        efd_pkg::REG_BANK_COUNT: num_banks = val[4:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_writes.size();
    endfunction

    task log_mismatch(string msg);
      mismatches++;
      if (mismatches <= 100) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task field_check(string name, logic [10:0] g, logic [10:0] w);
      if (g !== w)
        log_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h", checked, name, g, w));
    endtask

    task check_write(fuse_result_t got);
      fuse_result_t want;
      if (pending_writes.size() == 0) begin
        log_mismatch($sformatf("unexpected result kind=%0d addr=0x%0h value=0x%0h",
                               got.kind, got.addr, got.value));
        return;
      end
      want = pending_writes.pop_front();
      field_check("kind", got.kind, want.kind);
      field_check("log_address", got.addr, want.addr);
      field_check("log_value", got.value, want.value);
      field_check("addr_error", got.err, want.err);
      field_check("bank_index", got.bank, want.bank);
      field_check("used_length", got.used, want.used);
      field_check("end_found", got.found, want.found);
      field_check("current_bank", got.cur_bank, want.cur_bank);
      field_check("last", got.last, want.last);
      checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = efd_pkg::REG_USABLE_LENGTH;
  logic [10:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [7:0] phys_byte = '0;
  logic bank_last = 1'b0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic kind;
  logic [9:0] log_address;
  logic [7:0] log_value;
  logic addr_error;
  logic [3:0] bank_index;
  logic [9:0] used_length;
  logic end_found;
  logic [3:0] current_bank;
  logic last;

  log_write_board sb;
  int items_sent = 0;
  int quiet_cycles = 0;

  efuse_map_decoder DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .phys_byte(phys_byte),
    .bank_last(bank_last),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .kind(kind),
    .log_address(log_address),
    .log_value(log_value),
    .addr_error(addr_error),
    .bank_index(bank_index),
    .used_length(used_length),
    .end_found(end_found),
    .current_bank(current_bank),
    .last(last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // idle regimes: sender dense / receiver heavy, then swapped, then none
  function int tx_idle_pct();
    return (items_sent < 45) ? 7 : (items_sent < 90) ? 75 : 0;
  endfunction

  function int rx_stall_pct();
    return (items_sent < 45) ? 75 : (items_sent < 90) ? 7 : 0;
  endfunction

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_write('{kind, log_address, log_value, addr_error, bank_index, used_length,
                       end_found, current_bank, last});
    result_stall <= ($urandom_range(0, 99) < rx_stall_pct());
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("efuse_map_decoder verification failed");
      $finish;
    end
  end

  task automatic put_byte(input logic [7:0] b, input logic bl);
    while ($urandom_range(0, 99) < tx_idle_pct()) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    phys_byte <= b;
    bank_last <= bl;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_byte(b, bl);
    items_sent++;
  endtask

  task automatic cfg_put(input logic [1:0] idx, input logic [10:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic write_config(input int ul, input int ls, input int first, input int cnt);
    cfg_put(efd_pkg::REG_USABLE_LENGTH, 11'(ul));
    cfg_put(efd_pkg::REG_LOG_SIZE, 11'(ls));
    cfg_put(efd_pkg::REG_START_BANK, 11'(first));
    cfg_put(efd_pkg::REG_BANK_COUNT, 11'(cnt));
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly well-formed entries with random content, plus end markers,
  // short 0xff runs and noise; sometimes cut mid-entry
  task automatic send_bank(input int unsigned len);
    logic [7:0] bytes[$];
    logic [7:0] h;
    int unsigned r, nd;
    while (bytes.size() < len) begin
      r = $urandom_range(0, 99);
      nd = 0;
      if (r < 50) begin
        h = 8'($urandom);
        if (h[3:0] == 4'hf) h[3:0] = 4'($urandom_range(0, 14));
        bytes.push_back(h);
        for (int j = 0; j < 4; j++) if (!h[j]) nd += 2;
      end else if (r < 75) begin
        h = 8'($urandom);
        bytes.push_back({h[7:4], 4'hf});
        h = 8'($urandom);
        bytes.push_back(h);
        for (int j = 0; j < 4; j++) if (!h[j]) nd += 2;
      end else if (r < 83) begin
        repeat (8) bytes.push_back(8'hff);
      end else if (r < 91) begin
        repeat ($urandom_range(1, 7)) bytes.push_back(8'hff);
      end else begin
        repeat ($urandom_range(1, 3)) bytes.push_back(8'($urandom));
      end
      repeat (nd) bytes.push_back(8'($urandom));
    end
    if ($urandom_range(0, 1) == 0) while (bytes.size() > len) void'(bytes.pop_back());
    foreach (bytes[i]) put_byte(bytes[i], i == bytes.size() - 1);
  endtask

  task automatic directed_bank_pair();
    logic [7:0] seq0[23] = '{8'h23, 8'h00, 8'hff, 8'h55, 8'haa,
                             8'h3f, 8'hfe, 8'h12, 8'h34,
                             8'hff, 8'hff, 8'h0e, 8'hc3, 8'h3c,
                             8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                             8'h5a};
    foreach (seq0[i]) put_byte(seq0[i], i == 22);
    // header alone with bank_last: remaining words flushed as 0xff
    put_byte(8'h41, 1'b1);
    // bank limit reached: ignored
    put_byte(8'h00, 1'b0);
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    write_config(504, 512, 0, 2);
    directed_bank_pair();
    drain();

    write_config(512, 1024, 3, 3);
    repeat (3) send_bank(10);
    repeat (2) put_byte(8'($urandom), 1'($urandom));
    drain();

    write_config(0, 1024, 15, 16);
    repeat (4) send_bank(1);
    drain();

    write_config(8, 0, 7, 2);
    repeat (2) send_bank(12);
    drain();

    write_config(100, 200, 5, 0);
    repeat (3) put_byte(8'($urandom), 1'($urandom));
    drain();

    write_config(300, 100, 1, 3);
    repeat (3) send_bank(8);
    drain();

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("efuse_map_decoder verification clean");
    else
      $display("efuse_map_decoder verification failed");
    $finish;
  end
endmodule
